/* rtl/rdld_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row dictionary line decoder package
// Shared constants, phase codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package rdld_pkg;

   localparam int LineBytesDef  = 160;
   localparam int HorizBytesDef = 20;
   localparam int MaxVertDef    = 127;

   localparam logic [7:0] RawFlag  = 8'h80;
   localparam logic [7:0] VertMask = 8'h7f;

   localparam logic [0:0] CsrPages = 1'b0;
   localparam logic [0:0] CsrRows  = 1'b1;

   typedef enum logic [7:0] {
      PH_COUNT   = 8'b0000_0001,
      PH_CONTROL = 8'b0000_0010,
      PH_RAW     = 8'b0000_0100,
      PH_HORIZ   = 8'b0000_1000,
      PH_VERT    = 8'b0001_0000,
      PH_LITERAL = 8'b0010_0000,
      PH_HALT    = 8'b0100_0000,
      PH_DONE    = 8'b1000_0000
   } phase_type;

   // Controller state for the sequencer.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_BYTE  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_CLEAR = 5'b10000
   } ctrl_state_type;

   typedef struct packed {
      logic load_byte;   // process the held input byte in the current phase
      logic walk_step;   // decide one line byte from the bitmaps
      logic clear_step;  // clear one line store entry
      logic emit;        // push the assembled group to the output register
   } cmd_type;

   typedef struct packed {
      logic walking;     // phase is the bitmap walk and no literal is awaited
      logic clearing;    // line store clear sweep in progress
      logic group_ready; // a group waits to be emitted
   } stat_type;

endpackage
`default_nettype wire

/* rtl/rdld_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row dictionary line decoder controller
// Sequences input words, walk steps, clear sweeps and group emission.
// ----------------------------------------------------------------------------
module rdld_ctrl
   import rdld_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire logic     out_free,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // A new word enters only when nothing is left to do or deliver.
            if (stat.group_ready) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
               end
            end else if (stat.clearing) begin
               cmd.clear_step = 1'b1;
            end else if (stat.walking) begin
               // The line store and vertical bitmap reads settle in this cycle.
               state_in = ST_WALK;
            end else begin
               in_ready = 1'b1;
               if (in_valid) cmd.load_byte = 1'b1;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/rdld_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row dictionary line decoder datapath
// Line store, bitmaps, counters and the result register.
// ----------------------------------------------------------------------------
module rdld_dp
   import rdld_pkg::*;
#(
   parameter int LINE_BYTES         = LineBytesDef,
   parameter int HORIZONTAL_BYTES   = HorizBytesDef,
   parameter int MAX_VERTICAL_BYTES = MaxVertDef
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output stat_type        stat,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_restart,
   input  wire logic [1:0] pages_cfg,
   input  wire logic [7:0] rows_cfg,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic            out_free,
   output logic [31:0]     out_word,
   output logic [5:0]      out_index,
   output logic [7:0]      out_row,
   output logic            out_page,
   output logic            out_lrow,
   output logic            out_limg,
   output logic            out_bad
);

   localparam int LW = $clog2(LINE_BYTES);
   localparam int HW = (HORIZONTAL_BYTES > 1) ? $clog2(HORIZONTAL_BYTES) : 1;
   localparam int VW = (MAX_VERTICAL_BYTES > 1) ? $clog2(MAX_VERTICAL_BYTES) : 1;
   localparam int PW = LW + 1;

   phase_type        phase_ff, phase_in;
   logic [7:0]       lstore [LINE_BYTES];
   logic [7:0]       hbits [HORIZONTAL_BYTES];
   logic [7:0]       vbits [MAX_VERTICAL_BYTES];
   logic [6:0]       vlen_ff, vlen_in;
   logic [7:0]       fill_ff, fill_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [9:0]       vptr_ff, vptr_in;
   logic [7:0]       prev_ff, prev_in;
   logic [7:0]       row_ff, row_in;
   logic             page_ff, page_in;
   logic             clr_ff, clr_in;
   logic [PW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [7:0]       grp_ff [4];
   logic             gready_ff, gready_in;
   logic             glrow_ff, glimg_ff, glrow_in, glimg_in;
   logic [5:0]       gidx_ff, gidx_in;
   logic [7:0]       growr_ff, growr_in;
   logic             gpage_ff, gpage_in;
   logic             gbad_ff, gbad_in;
   logic [7:0]       above_ff;
   logic [7:0]       vb_byte_ff;

   logic             wr_en;
   logic [LW-1:0]    wr_addr;
   logic [7:0]       wr_data;
   logic             two_pages;
   logic             hbit, vbit;
   logic [LW-1:0]    pos_ix;
   logic [7:0]       hb_byte;
   logic             fin;
   logic [7:0]       fin_byte;
   phase_type        ph_eff;

   assign two_pages = pages_cfg[1];
   assign pos_ix    = pos_ff[LW-1:0];
   assign hb_byte   = (32'(pos_ff >> 3) < HORIZONTAL_BYTES) ? hbits[HW'(pos_ff >> 3)] : 8'd0;
   assign hbit      = (32'(pos_ff >> 3) < HORIZONTAL_BYTES) ? hb_byte[3'd7 - pos_ff[2:0]]
                                                              : 1'b0;
   assign vbit      = ({vptr_ff} < {vlen_ff, 3'b000}) ? vb_byte_ff[3'd7 - vptr_ff[2:0]]
                                                      : 1'b0;
   assign ph_eff    = in_restart ? PH_COUNT : phase_ff;

   assign stat.walking     = (phase_ff == PH_LITERAL) && (fill_ff == 8'd1);
   assign stat.clearing    = clr_ff;
   assign stat.group_ready = gready_ff;

   // Line store is written through one port; the byte above the walk
   // position is read into a register in the cycle before the walk step.
   always_ff @(posedge clock) begin
      if (wr_en) lstore[wr_addr] <= wr_data;
      above_ff <= lstore[pos_ix];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte && ph_eff == PH_HORIZ)
         hbits[HW'(fill_ff)] <= in_byte;
      if (cmd.load_byte && ph_eff == PH_VERT && 32'(fill_ff) < MAX_VERTICAL_BYTES)
         vbits[VW'(fill_ff)] <= in_byte;
      vb_byte_ff <= (32'(vptr_ff >> 3) < MAX_VERTICAL_BYTES) ? vbits[VW'(vptr_ff >> 3)]
                                                             : 8'd0;
   end

   always_comb begin
      phase_in   = phase_ff;
      vlen_in    = vlen_ff;
      fill_in    = fill_ff;
      pos_in     = pos_ff;
      vptr_in    = vptr_ff;
      prev_in    = prev_ff;
      row_in     = row_ff;
      page_in    = page_ff;
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      gready_in  = gready_ff;
      glrow_in   = glrow_ff;
      glimg_in   = glimg_ff;
      gidx_in    = gidx_ff;
      growr_in   = growr_ff;
      gpage_in   = gpage_ff;
      gbad_in    = gbad_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ix;
      wr_data    = 8'd0;
      fin        = 1'b0;
      fin_byte   = 8'd0;

      if (cmd.emit) gready_in = 1'b0;

      if (cmd.clear_step) begin
         wr_en      = 1'b1;
         wr_addr    = clr_cnt_ff[LW-1:0];
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (32'(clr_cnt_ff) == LINE_BYTES - 1) clr_in = 1'b0;
      end

      if (cmd.load_byte) begin
         if (in_restart) begin
            vlen_in = '0; fill_in = '0; pos_in = '0; vptr_in = '0;
            prev_in = '0; row_in = '0; page_in = 1'b0; phase_in = PH_COUNT;
         end
         unique case (ph_eff)
            PH_COUNT: begin
               if (in_byte != rows_cfg) begin
                  gready_in = 1'b1; gbad_in = 1'b1; gidx_in = '0; growr_in = '0;
                  gpage_in = in_restart ? 1'b0 : page_ff;
                  glrow_in = 1'b0; glimg_in = 1'b0;
                  row_in = '0; phase_in = PH_HALT;
               end else begin
                  clr_in = 1'b1; clr_cnt_in = '0;
                  prev_in = '0; row_in = '0; pos_in = '0;
                  if (rows_cfg == 8'd0) begin
                     if ((in_restart ? 1'b0 : page_ff) || !two_pages) phase_in = PH_DONE;
                     else begin page_in = 1'b1; phase_in = PH_COUNT; end
                  end else phase_in = PH_CONTROL;
               end
            end
            PH_CONTROL: begin
               pos_in = '0; fill_in = '0;
               if ((in_byte & RawFlag) != 8'd0) phase_in = PH_RAW;
               else begin vlen_in = 7'(in_byte & VertMask); phase_in = PH_HORIZ; end
            end
            PH_RAW: begin
               fin = 1'b1; fin_byte = in_byte;
            end
            PH_HORIZ: begin
               fill_in = fill_ff + 1'b1;
               if (32'(fill_in) >= HORIZONTAL_BYTES) begin
                  vptr_in = '0;
                  if (vlen_ff == 7'd0) begin phase_in = PH_LITERAL; fill_in = 8'd1; end
                  else begin phase_in = PH_VERT; fill_in = '0; end
               end
            end
            PH_VERT: begin
               fill_in = fill_ff + 1'b1;
               if (fill_in >= {1'b0, vlen_ff}) begin
                  phase_in = PH_LITERAL; fill_in = 8'd1;
               end
            end
            PH_LITERAL: begin
               // fill of zero marks a pending literal
               fin = 1'b1; fin_byte = in_byte; fill_in = 8'd1;
            end
            default: ;
         endcase
      end

      if (cmd.walk_step) begin
         if (!hbit) begin
            fin = 1'b1; fin_byte = prev_ff;
         end else begin
            vptr_in = vptr_ff + 1'b1;
            if (vbit) fill_in = 8'd0;
            else begin fin = 1'b1; fin_byte = above_ff; end
         end
      end

      if (fin) begin
         wr_en = 1'b1; wr_addr = pos_ix; wr_data = fin_byte; prev_in = fin_byte;
         if (pos_ff[1:0] == 2'd3 || 32'(pos_ff) == LINE_BYTES - 1) begin
            gready_in = 1'b1; gbad_in = 1'b0;
            gidx_in   = 6'(pos_ff >> 2);
            growr_in  = row_ff; gpage_in = page_ff;
            glrow_in  = (32'(pos_ff) == LINE_BYTES - 1);
            glimg_in  = glrow_in && (row_ff + 8'd1 == rows_cfg) && (page_ff || !two_pages);
         end
         pos_in = pos_ff + 1'b1;
         if (32'(pos_in) >= LINE_BYTES) begin
            pos_in = '0;
            row_in = row_ff + 8'd1;
            if (row_in == rows_cfg) begin
               if (page_ff || !two_pages) phase_in = PH_DONE;
               else begin page_in = 1'b1; row_in = '0; phase_in = PH_COUNT; end
            end else phase_in = PH_CONTROL;
         end
      end
   end

   // Group bytes gathered as they are decided, from the write port.
   always_ff @(posedge clock) begin
      if (fin) grp_ff[pos_ff[1:0]] <= fin_byte;
      if (fin && 32'(pos_ff) == LINE_BYTES - 1) begin
         for (int k = 0; k < 4; k++)
            if (k > int'(pos_ff[1:0])) grp_ff[k] <= 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT; vlen_ff <= '0; fill_ff <= '0; pos_ff <= '0;
         vptr_ff <= '0; prev_ff <= '0; row_ff <= '0; page_ff <= 1'b0;
         clr_ff <= 1'b1; clr_cnt_ff <= '0; gready_ff <= 1'b0; out_valid <= 1'b0;
      end else begin
         phase_ff <= phase_in; vlen_ff <= vlen_in; fill_ff <= fill_in; pos_ff <= pos_in;
         vptr_ff <= vptr_in; prev_ff <= prev_in; row_ff <= row_in; page_ff <= page_in;
         clr_ff <= clr_in; clr_cnt_ff <= clr_cnt_in; gready_ff <= gready_in;
         if (cmd.emit) out_valid <= 1'b1;
         else if (out_ready) out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      glrow_ff <= glrow_in; glimg_ff <= glimg_in; gidx_ff <= gidx_in;
      growr_ff <= growr_in; gpage_ff <= gpage_in; gbad_ff <= gbad_in;
      if (cmd.emit) begin
         out_word  <= gbad_ff ? 32'd0 : {grp_ff[3], grp_ff[2], grp_ff[1], grp_ff[0]};
         out_index <= gidx_ff; out_row <= growr_ff; out_page <= gpage_ff;
         out_lrow  <= glrow_ff; out_limg <= glimg_ff; out_bad <= gbad_ff;
      end
   end

   assign out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

/* rtl/row_dictionary_line_decoder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Row dictionary line decoder
// Decodes row-dictionary compressed pixel bytes into four-byte line groups.
// ----------------------------------------------------------------------------
// One stream word is taken per free cycle. Count, control, raw, bitmap and
// literal words are each processed as they are taken, and an emit follows
// when the word closes a group and the result register is free. After the
// bitmaps the walk decides each line byte with a registered line store and
// vertical bitmap read followed by a step that decides and writes the byte,
// so a word that starts a walk keeps the input stalled until the walk stops,
// and longer while the receiver stalls.
// After reset and after each row-count word that matches the row setting the
// line store is cleared, one entry per cycle, and no word is accepted during
// the sweep.
module row_dictionary_line_decoder_unit
   import rdld_pkg::*;
#(
   parameter int LINE_BYTES         = LineBytesDef,
   parameter int HORIZONTAL_BYTES   = HorizBytesDef,
   parameter int MAX_VERTICAL_BYTES = MaxVertDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // stream_byte
   input  wire logic        req_tuser,   // restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // line_word, word_index, row_number, page_number
   output logic             rsp_tlast,   // last_of_row
   output logic [1:0]       rsp_tuser,   // last_of_image, bad_row_count
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);

   cmd_type     cmd;
   stat_type    stat;
   logic        out_free;
   logic [1:0]  pages_ff;
   logic [7:0]  rows_ff;
   logic [31:0] w;
   logic [5:0]  ix;
   logic [7:0]  rw;
   logic        pg, lr, li, bd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff <= 2'd1; rows_ff <= 8'd192;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrPages: pages_ff <= csr_data[1:0];
            CsrRows:  rows_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   rdld_ctrl u_ctrl (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .out_free, .stat, .cmd
   );

   rdld_dp #(
      .LINE_BYTES(LINE_BYTES), .HORIZONTAL_BYTES(HORIZONTAL_BYTES),
      .MAX_VERTICAL_BYTES(MAX_VERTICAL_BYTES)
   ) u_dp (
      .clock, .reset, .cmd, .stat, .in_byte(req_tdata), .in_restart(req_tuser),
      .pages_cfg(pages_ff), .rows_cfg(rows_ff), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_free, .out_word(w), .out_index(ix),
      .out_row(rw), .out_page(pg), .out_lrow(lr), .out_limg(li), .out_bad(bd)
   );

   assign rsp_tdata = {1'b0, pg, rw, ix, w};
   assign rsp_tlast = lr;
   assign rsp_tuser = {bd, li};

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_byte, cmd.walk_step, cmd.clear_step, cmd.emit}))
      else $error("more than one command issued");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !req_tready)
      else $error("word accepted during clear sweep");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("emitted group lost");

endmodule
`default_nettype wire

/* verif/row_dictionary_line_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Row dictionary line decoder testbench
// Feeds compressed pixel byte streams for images (raw rows, bitmap rows,
// wrong row counts, restarts and trailing bytes) under several page and row
// settings. A line decoder model in the scoreboard predicts every four-byte
// group, and each group from the block is compared field by field.
// ----------------------------------------------------------------------------
module row_dictionary_line_decoder_unit_tb;
   import rdld_pkg::*;

   localparam int LineBytes  = LineBytesDef;
   localparam int HorizBytes = HorizBytesDef;
   localparam int MaxVert    = MaxVertDef;
   localparam int CycleLimit = 1500000;
   localparam int SettleCycles = 500;

   typedef struct packed {
      logic [31:0] line_word;
      logic [5:0]  word_index;
      logic [7:0]  row_number;
      logic        page_number;
      logic        last_of_row;
      logic        last_of_image;
      logic        bad_row_count;
   } line_group_type;

   class line_scoreboard;
      logic [1:0] pages_cfg = 2'd1;
      logic [7:0] rows_cfg  = 8'd192;
      phase_type  phase;
      logic [7:0] line_store [LineBytes];
      logic [7:0] horiz_map [HorizBytes];
      logic [7:0] vert_map [MaxVert];
      int         vert_len, fill, pos, vert_ptr, row;
      logic [7:0] prev_byte;
      logic       page;
      line_group_type groups_due[$];
      int         errors, groups_checked, bad_counts;

      function void clear_state();
         phase = PH_COUNT;
         foreach (line_store[i]) line_store[i] = 8'h00;
         foreach (horiz_map[i]) horiz_map[i] = 8'h00;
         foreach (vert_map[i]) vert_map[i] = 8'h00;
         vert_len = 0; fill = 0; pos = 0; vert_ptr = 0; row = 0;
         prev_byte = 8'h00; page = 1'b0;
      endfunction

      function int page_total();
         return (pages_cfg >= 2) ? 2 : 1;
      endfunction

      function void push_group(logic [31:0] w, int idx, bit lrow, bit limg, bit bad);
         line_group_type g;
         g.line_word = w;
         g.word_index = idx[5:0];
         g.row_number = row[7:0];
         g.page_number = page;
         g.last_of_row = lrow;
         g.last_of_image = limg;
         g.bad_row_count = bad;
         groups_due.push_back(g);
      endfunction

      function void end_page();
         if (page + 1 >= page_total()) begin
            phase = PH_DONE;
         end else begin
            page = 1'b1;
            row = 0;
            phase = PH_COUNT;
         end
      endfunction

      // The byte at pos is decided; a group closes on every fourth byte and at the end of the line.
      function void finish_byte();
         bit last;
         bit limg;
         int base;
         logic [31:0] w;
         last = (pos + 1 == LineBytes);
         if ((pos % 4) == 3 || last) begin
            base = pos - (pos % 4);
            w = '0;
            for (int k = 0; k < 4; k++)
               if (base + k < LineBytes) w[8*k +: 8] = line_store[base + k];
            limg = last && (row + 1 == rows_cfg) && (page + 1 >= page_total());
            push_group(w, pos / 4, last, limg, 1'b0);
         end
         pos++;
         if (pos >= LineBytes) begin
            pos = 0;
            row = (row + 1) & 8'hff;
            if (row == rows_cfg) end_page();
            else phase = PH_CONTROL;
         end
      endfunction

      function void walk_line();
         int p;
         bit hbit, vbit;
         phase = PH_LITERAL;
         while (phase == PH_LITERAL) begin
            p = pos;
            hbit = 1'b0;
            if ((p / 8) < HorizBytes) hbit = horiz_map[p / 8][7 - (p % 8)];
            if (!hbit) begin
               line_store[p] = prev_byte;
            end else begin
               vbit = 1'b0;
               if (vert_ptr < vert_len * 8 && (vert_ptr / 8) < MaxVert)
                  vbit = vert_map[vert_ptr / 8][7 - (vert_ptr % 8)];
               vert_ptr = (vert_ptr + 1) & 10'h3ff;
               if (vbit) return;
            end
            prev_byte = line_store[p];
            finish_byte();
         end
      endfunction

      function void note_byte(logic [7:0] b, bit restart);
         if (restart) clear_state();
         case (phase)
            PH_COUNT: begin
               if (b != rows_cfg) begin
                  push_group('0, 0, 1'b0, 1'b0, 1'b1);
                  row = 0;
                  phase = PH_HALT;
               end else begin
                  foreach (line_store[i]) line_store[i] = 8'h00;
                  prev_byte = 8'h00;
                  row = 0;
                  pos = 0;
                  if (rows_cfg == 0) end_page();
                  else phase = PH_CONTROL;
               end
            end
            PH_CONTROL: begin
               pos = 0;
               fill = 0;
               if ((b & RawFlag) != 8'h00) begin
                  phase = PH_RAW;
               end else begin
                  vert_len = int'(b & VertMask);
                  phase = PH_HORIZ;
               end
            end
            PH_RAW: begin
               line_store[pos] = b;
               prev_byte = b;
               finish_byte();
            end
            PH_HORIZ: begin
               horiz_map[fill % HorizBytes] = b;
               fill++;
               if (fill >= HorizBytes) begin
                  fill = 0;
                  vert_ptr = 0;
                  if (vert_len == 0) walk_line();
                  else phase = PH_VERT;
               end
            end
            PH_VERT: begin
               if (fill < MaxVert) vert_map[fill] = b;
               fill++;
               if (fill >= vert_len) begin
                  fill = 0;
                  walk_line();
               end
            end
            PH_LITERAL: begin
               line_store[pos] = b;
               prev_byte = b;
               finish_byte();
               if (phase == PH_LITERAL) walk_line();
            end
            default: begin
            end
         endcase
      endfunction

      function void check_group(line_group_type got);
         line_group_type want;
         if (groups_due.size() == 0) begin
            $error("unexpected word: line_word %h word_index %0d", got.line_word,
                   got.word_index);
            errors++;
            return;
         end
         want = groups_due.pop_front();
         groups_checked++;
         if (got.bad_row_count) bad_counts++;
         if (got.line_word !== want.line_word) begin
            $error("line_word expected %h actual %h", want.line_word, got.line_word);
            errors++;
         end
         if (got.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
            errors++;
         end
         if (got.row_number !== want.row_number) begin
            $error("row_number expected %0d actual %0d", want.row_number, got.row_number);
            errors++;
         end
         if (got.page_number !== want.page_number) begin
            $error("page_number expected %0d actual %0d", want.page_number,
                   got.page_number);
            errors++;
         end
         if (got.last_of_row !== want.last_of_row) begin
            $error("last_of_row expected %0d actual %0d", want.last_of_row,
                   got.last_of_row);
            errors++;
         end
         if (got.last_of_image !== want.last_of_image) begin
            $error("last_of_image expected %0d actual %0d", want.last_of_image,
                   got.last_of_image);
            errors++;
         end
         if (got.bad_row_count !== want.bad_row_count) begin
            $error("bad_row_count expected %0d actual %0d", want.bad_row_count,
                   got.bad_row_count);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   line_scoreboard decoder_sb;
   int  cycle_count;
   int  words_sent;
   int  images_run;
   int  burst_left;
   bit  hold_request;

   row_dictionary_line_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL row_dictionary_line_decoder_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      line_group_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.line_word = rsp_tdata[31:0];
         got.word_index = rsp_tdata[37:32];
         got.row_number = rsp_tdata[45:38];
         got.page_number = rsp_tdata[46];
         got.last_of_row = rsp_tlast;
         got.last_of_image = rsp_tuser[0];
         got.bad_row_count = rsp_tuser[1];
         decoder_sb.check_group(got);
      end
   end

   // Receiver: switches between free flow and random stalls, and on request
   // holds off for a long stretch so that the block backs up.
   initial begin
      int mode_left;
      int mode;
      rsp_tready = 1'b0;
      mode_left = 0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (700) @(negedge clock);
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 3) != 0);
            default: rsp_tready = ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic put_byte(input logic [7:0] b, input bit restart);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tuser = restart;
      do @(posedge clock); while (!req_tready);
      decoder_sb.note_byte(b, restart);
      words_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (decoder_sb.groups_due.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CsrPages) decoder_sb.pages_cfg = value[1:0];
      else decoder_sb.rows_cfg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One image driven by the predicted phase; stops early after stop_rows
   // rows of the first page so that long settings stay short.
   task automatic run_image(input int stop_rows);
      logic [7:0] b;
      int density;
      b = decoder_sb.rows_cfg;
      if ($urandom_range(0, 9) == 0) b = 8'($urandom);
      put_byte(b, 1'b1);
      density = 0;
      while (decoder_sb.phase != PH_DONE && decoder_sb.phase != PH_HALT) begin
         if (decoder_sb.phase == PH_CONTROL && decoder_sb.row >= stop_rows) return;
         if ($urandom_range(0, 600) == 0) return;
         case (decoder_sb.phase)
            PH_COUNT: put_byte(decoder_sb.rows_cfg, 1'b0);
            PH_CONTROL: begin
               density = $urandom_range(0, 3);
               if ($urandom_range(0, 5) == 0) begin
                  b = RawFlag | (8'($urandom) & VertMask);
               end else begin
                  case ($urandom_range(0, 9))
                     0: b = VertMask;
                     1: b = 8'h00;
                     default: b = 8'($urandom_range(1, 6));
                  endcase
               end
               put_byte(b, 1'b0);
            end
            PH_HORIZ: begin
               case (density)
                  0: b = 8'($urandom & $urandom & $urandom);
                  1: b = 8'($urandom);
                  2: b = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
                  default: b = 8'($urandom & $urandom);
               endcase
               put_byte(b, 1'b0);
            end
            default: put_byte(8'($urandom), 1'b0);
         endcase
      end
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom), 1'b0);
      images_run++;
   endtask

   initial begin
      logic [7:0] rows_pick;
      decoder_sb = new();
      decoder_sb.clear_state();
      cycle_count = 0;
      words_sent = 0;
      images_run = 0;
      burst_left = 0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = CsrPages;
      csr_data = 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a wrong row count halts, bytes are then ignored, and a
      // one-row image of all-repeat bytes is followed by an ignored byte.
      write_csr(CsrPages, 8'd1);
      write_csr(CsrRows, 8'd1);
      put_byte(8'hff, 1'b1);
      put_byte(8'h01, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h01, 1'b1);
      put_byte(8'h00, 1'b0);
      repeat (HorizBytes) put_byte(8'h00, 1'b0);
      put_byte(8'h5a, 1'b0);
      wait_drained();

      // The receiver stalls long while the sender keeps going.
      write_csr(CsrRows, 8'd2);
      hold_request = 1'b1;
      run_image(2);
      wait_drained();

      // Zero rows per page on two pages, and the two out-of-range page codes.
      write_csr(CsrPages, 8'd3);
      write_csr(CsrRows, 8'd0);
      run_image(1);
      put_byte(8'h00, 1'b1);
      put_byte(8'h00, 1'b0);
      wait_drained();
      write_csr(CsrPages, 8'd0);
      write_csr(CsrRows, 8'd255);
      run_image(1);
      wait_drained();

      while (words_sent < 220) begin
         case ($urandom_range(0, 5))
            0: rows_pick = 8'd255;
            1: rows_pick = 8'd1;
            default: rows_pick = 8'($urandom_range(1, 3));
         endcase
         write_csr(CsrPages, 8'($urandom_range(0, 3)));
         write_csr(CsrRows, rows_pick);
         repeat ($urandom_range(1, 3)) run_image(3);
         wait_drained();
      end

      wait_drained();
      $display("Sent %0d stream words over %0d images; checked %0d groups,",
               words_sent, images_run, decoder_sb.groups_checked);
      $display("%0d of them row-count errors.", decoder_sb.bad_counts);
      if (decoder_sb.errors == 0 && decoder_sb.groups_due.size() == 0) begin
         $display("PASS row_dictionary_line_decoder_unit");
      end else begin
         $display("FAIL row_dictionary_line_decoder_unit");
      end
      $finish;
   end

endmodule

/* row_dictionary_line_decoder_unit.f */
rtl/rdld_pkg.sv
rtl/rdld_ctrl.sv
rtl/rdld_dp.sv
rtl/row_dictionary_line_decoder_unit.sv
verif/row_dictionary_line_decoder_unit_tb.sv
